// ----- src/ras_pkg.sv -----
// random access set: shared types and codes
// used by ras_ctrl, ras_dp and random_access_set
`default_nettype none
package ras_pkg;
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_PICK   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MOD,
    S_READ,
    S_WRITE,
    S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch input beat, clear counters
    logic search_en;  // step search address
    logic mod_en;     // one remainder step
    logic rd_last;    // read last slot (remove)
    logic rd_pick;    // read remainder slot (pick)
    logic wr_ins;     // write value at count
    logic wr_move;    // write moved value at found slot
    logic fin;        // emit result
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic search_done;
    logic found;
    logic mod_done;
    logic full;
    logic empty;
  } sts_t;
endpackage
`default_nettype wire

// ----- src/ras_ctrl.sv -----
// random access set controller state machine
// depends on ras_pkg
`default_nettype none
module ras_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  input  wire logic [1:0]   cmd_i,
  input  wire ras_pkg::sts_t sts_i,
  output ras_pkg::ctl_t     ctl_o,
  output logic              busy,
  output logic [1:0]        status_o
);
  import ras_pkg::*;

  state_e state_q, state_d;
  cmd_e   cmd_q, cmd_d;
  status_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_NOP;
      st_q    <= ST_DONE;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    st_d    = st_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          cmd_d = cmd_e'(cmd_i);
          st_d  = ST_DONE;
          unique case (cmd_e'(cmd_i))
            CMD_INSERT, CMD_REMOVE: state_d = S_SEARCH;
            CMD_PICK:               state_d = S_MOD;
            default:                state_d = S_DONE;
          endcase
        end
      end
      S_SEARCH: begin
        if (sts_i.found || sts_i.search_done) begin
          if (cmd_q == CMD_INSERT) begin
            if (sts_i.found) begin
              st_d = ST_PRESENT;
              state_d = S_DONE;
            end else if (sts_i.full) begin
              st_d = ST_FULL;
              state_d = S_DONE;
            end else begin
              ctl_o.wr_ins = 1'b1;
              state_d = S_DONE;
            end
          end else if (sts_i.found) begin
            ctl_o.rd_last = 1'b1;
            state_d = S_WRITE;
          end else begin
            st_d = ST_PRESENT;
            state_d = S_DONE;
          end
        end else begin
          ctl_o.search_en = 1'b1;
        end
      end
      S_MOD: begin
        if (sts_i.empty) begin
          st_d = ST_EMPTY;
          state_d = S_DONE;
        end else if (sts_i.mod_done) begin
          ctl_o.rd_pick = 1'b1;
          state_d = S_READ;
        end else begin
          ctl_o.mod_en = 1'b1;
        end
      end
      S_READ:  state_d = S_DONE;
      S_WRITE: begin
        ctl_o.wr_move = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        ctl_o.fin = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy     = (state_q != S_IDLE);
  assign status_o = st_q;
endmodule
`default_nettype wire

// ----- src/ras_dp.sv -----
// random access set datapath: slot memory, count, search, remainder unit
// depends on ras_pkg
`default_nettype none
module ras_dp #(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned CW = $clog2(CAPACITY + 1),
  parameter int unsigned AW = $clog2(CAPACITY)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ras_pkg::ctl_t      ctl_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [31:0]        random_word_i,
  output ras_pkg::sts_t           sts_o,
  output logic [CW-1:0]           count_o,
  output logic signed [31:0]      rd_data_o
);
  import ras_pkg::*;

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rd_q;
  logic [CW-1:0] count_q;
  logic [31:0]   val_q;
  logic [CW-1:0] addr_q;    // search address; one beyond when done
  logic          hit_q;
  logic [AW-1:0] found_q;
  logic [31:0]   quo_q;     // dividend shifted out msb first
  logic [CW-1:0] rem_q;
  logic [5:0]    step_q;

  logic          cmp_hit;
  logic [CW:0]   rem_sh;
  logic [CW:0]   rem_sub;

  // registered read compare: rd_q holds slot addr_q-1
  assign cmp_hit = (addr_q != '0) && (addr_q <= count_q) && (rd_q == val_q);
  assign rem_sh  = {rem_q, quo_q[31]};
  assign rem_sub = rem_sh - {1'b0, count_q};

  // read data holds between reads so a picked or moved value survives
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_ins) mem[count_q[AW-1:0]] <= val_q;
    if (ctl_i.wr_move) mem[found_q] <= rd_q;
    if (ctl_i.rd_last)
      rd_q <= mem[AW'(count_q - CW'(1))];
    else if (ctl_i.rd_pick)
      rd_q <= mem[rem_q[AW-1:0]];
    else if (ctl_i.search_en)
      rd_q <= mem[addr_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      val_q  <= value_i;
      quo_q  <= random_word_i;
      rem_q  <= '0;
      addr_q <= '0;
      step_q <= '0;
    end else begin
      if (ctl_i.search_en) begin
        addr_q <= addr_q + CW'(1);
        if (cmp_hit) found_q <= AW'(addr_q - CW'(1));
      end
      if (ctl_i.mod_en) begin
        quo_q  <= {quo_q[30:0], 1'b0};
        step_q <= step_q + 6'd1;
        rem_q  <= rem_sub[CW] ? rem_sh[CW-1:0] : rem_sub[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (ctl_i.load) hit_q <= 1'b0;
      else if (ctl_i.search_en && cmp_hit) hit_q <= 1'b1;
      if (ctl_i.wr_ins) count_q <= count_q + CW'(1);
      if (ctl_i.wr_move) count_q <= count_q - CW'(1);
    end
  end

  // address past count means every slot has been compared
  assign sts_o.found       = hit_q;
  assign sts_o.search_done = (addr_q > count_q);
  assign sts_o.mod_done    = (step_q == 6'd32);
  assign sts_o.full        = (count_q == CW'(CAPACITY));
  assign sts_o.empty       = (count_q == '0);
  assign count_o           = count_q;
  assign rd_data_o         = rd_q;
endmodule
`default_nettype wire

// ----- src/random_access_set.sv -----
// random access set top level: controller plus datapath
// depends on ras_pkg, ras_ctrl, ras_dp
//
// channel  | ports                                  | handshake
// command  | start, cmd_i, value_i, random_word_i  | accepted at start & !busy
// result   | done_o, status_o, picked_value_o, ...  | one-cycle strobe done_o
//
// insert and remove run a linear search that reads one slot a cycle through
// the single memory read port. pick runs the one-bit-a-step remainder unit
// and ends early when the set is empty. nop goes straight to done.
// busy stays high until done. reset clears count but not the slots; slot
// contents are undefined until written. results cannot be stalled.
`default_nettype none
module random_access_set #(
  parameter int unsigned CAPACITY = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         cmd_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [31:0]        random_word_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic signed [31:0]      picked_value_o,
  output logic [8:0]              member_count_o
);
  import ras_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  ctl_t ctl;
  sts_t sts;
  logic [CW-1:0] count;
  logic signed [31:0] rd_data;
  logic [1:0] st;
  logic is_pick_q;

  ras_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .cmd_i,
    .sts_i(sts), .ctl_o(ctl), .busy, .status_o(st)
  );

  ras_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .value_i, .random_word_i,
    .sts_o(sts), .count_o(count), .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) is_pick_q <= 1'b0;
    else if (ctl.load) is_pick_q <= 1'b0;
    else if (ctl.rd_pick) is_pick_q <= 1'b1;
  end

  assign done_o         = ctl.fin;
  assign status_o       = st;
  assign picked_value_o = is_pick_q ? rd_data : '0;
  assign member_count_o = 9'(count);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(CAPACITY)) else $error("count above capacity");
  a_busy_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done without busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy after done");
  a_no_write_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.wr_ins && ctl.wr_move)) else $error("two writes at once");
endmodule
`default_nettype wire
